// ===== hw/rtl/stu_pkg.sv =====
// Package for the source tokenizer: token kinds, lexer modes, byte codes and helpers.
package stu_pkg;

  typedef enum logic [4:0] {
    K_LPAREN     = 5'd0,
    K_RPAREN     = 5'd1,
    K_LBRACKET   = 5'd2,
    K_RBRACKET   = 5'd3,
    K_LBRACE     = 5'd4,
    K_RBRACE     = 5'd5,
    K_COLON      = 5'd6,
    K_COMMA      = 5'd7,
    K_DOT        = 5'd8,
    K_EQUALS     = 5'd9,
    K_FUN        = 5'd10,
    K_IDENT      = 5'd11,
    K_INTEGER    = 5'd12,
    K_STR_BYTE   = 5'd13,
    K_STRING     = 5'd14,
    K_END        = 5'd15,
    K_BAD_ESC    = 5'd16,
    K_UNFINISHED = 5'd17,
    K_UNEXPECTED = 5'd18
  } kind_t;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_IDENT  = 3'd1,
    MODE_NUMBER = 3'd2,
    MODE_STRING = 3'd3,
    MODE_ESC    = 3'd4
  } mode_t;

  localparam int VALUE_W    = 64;
  localparam int MAX_RES    = 3;
  localparam int NUM_W      = 2;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = 2;
  localparam int CNT_W      = 3;

  localparam logic [2:0] KW_FULL = 3'd3;
  localparam logic [2:0] KW_NONE = 3'd7;
  localparam logic [2:0] KW_ONE  = 3'd1;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // Fields of one result that do not depend on the position width.
  typedef struct packed {
    kind_t               kind;
    logic [VALUE_W-1:0]  value;
    logic                final_item;
  } res_fix_t;

  // Fill status of the result queue.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             not_empty;
    logic             has_room;
  } fifo_stat_t;

  typedef struct packed {
    logic  hit;
    kind_t kind;
  } punct_t;

  function automatic punct_t punct_lookup(input logic [7:0] b);
    punct_t r;
    r.hit  = 1'b1;
    r.kind = K_LPAREN;
    unique case (b)
      8'h28:   r.kind = K_LPAREN;
      8'h29:   r.kind = K_RPAREN;
      8'h5B:   r.kind = K_LBRACKET;
      8'h5D:   r.kind = K_RBRACKET;
      8'h7B:   r.kind = K_LBRACE;
      8'h7D:   r.kind = K_RBRACE;
      8'h3A:   r.kind = K_COLON;
      8'h2C:   r.kind = K_COMMA;
      8'h2E:   r.kind = K_DOT;
      8'h3D:   r.kind = K_EQUALS;
      default: r.hit  = 1'b0;
    endcase
    return r;
  endfunction

  // Letters of the keyword "fun" by match position.
  function automatic logic [7:0] kw_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0:    c = CH_F;
      2'd1:    c = CH_U;
      2'd2:    c = CH_N;
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/stu_channels.sv =====
// Handshake channel interfaces for the tokenizer input bytes and result tokens.
interface stu_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] in_byte;
  modport source (output valid, op, in_byte, input ready);
  modport sink   (input valid, op, in_byte, output ready);
endinterface

interface stu_out_if import stu_pkg::*; #(parameter int POS_BITS = 24) ();
  logic                valid;
  logic                ready;
  kind_t               kind;
  logic [POS_BITS-1:0] begin_pos;
  logic [POS_BITS-1:0] end_pos;
  logic [VALUE_W-1:0]  value;
  logic                final_item;
  modport source (output valid, kind, begin_pos, end_pos, value, final_item, input ready);
  modport sink   (input valid, kind, begin_pos, end_pos, value, final_item, output ready);
endinterface

// ===== hw/rtl/source_tokenizer_unit.sv =====
// Top level of the streaming source tokenizer: lexer core plus result queue.
// Tokens caused by a byte enter the result queue at the end of that beat, and the output
// is valid in the cycle after it. Throughput: one source byte per cycle while at most one
// token is queued; a byte that yields several tokens drains at one beat per cycle while the
// output is ready, and input waits while two or more tokens sit in the four-entry queue.
// Reset (rst_n low, synchronous): lexer idle, offsets, number and keyword state zero,
// result queue empty.
module source_tokenizer_unit import stu_pkg::*; #(
  parameter int POS_BITS = 24
) (
  input  logic     clk,
  input  logic     rst_n,
  stu_in_if.sink   in_ch,
  stu_out_if.source out_ch
);

  // An input beat is taken only when the queue can hold the three tokens that the
  // worst byte (end of input inside a string) can produce. That check uses the
  // registered fill count, so the ready path never sees the lexer logic.
  logic                fire;
  logic [NUM_W-1:0]    push_num;
  res_fix_t            res_fix  [MAX_RES];
  logic [POS_BITS-1:0] res_beg  [MAX_RES];
  logic [POS_BITS-1:0] res_endp [MAX_RES];
  fifo_stat_t          stat;
  res_fix_t            head_fix;
  logic                pop;

  assign fire        = in_ch.valid && in_ch.ready;
  assign in_ch.ready = stat.has_room;

  // The lexer updates its state on each accepted beat and lists the tokens in order.
  stu_lexer #(.POS_BITS(POS_BITS)) u_lexer (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .op       (in_ch.op),
    .in_byte  (in_ch.in_byte),
    .push_num (push_num),
    .res_fix  (res_fix),
    .res_beg  (res_beg),
    .res_endp (res_endp)
  );

  // The queue is the result register: tokens leave it one beat at a time.
  assign pop = out_ch.valid && out_ch.ready;

  stu_result_fifo #(.POS_BITS(POS_BITS)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_num  (push_num),
    .push_fix  (res_fix),
    .push_beg  (res_beg),
    .push_endp (res_endp),
    .pop       (pop),
    .stat      (stat),
    .head_fix  (head_fix),
    .head_beg  (out_ch.begin_pos),
    .head_endp (out_ch.end_pos)
  );

  assign out_ch.valid      = stat.not_empty;
  assign out_ch.kind       = head_fix.kind;
  assign out_ch.value      = head_fix.value;
  assign out_ch.final_item = head_fix.final_item;

  // The queue never holds more entries than it has.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    stat.count <= CNT_W'(FIFO_DEPTH))
    else $error("result queue count exceeds its depth");

  // End of input always yields at least the end token.
  a_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && in_ch.op) |-> (push_num != '0))
    else $error("end of input produced no token");

  // A beat that produces tokens makes the output valid in the next cycle.
  a_token_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (push_num != '0)) |=> out_ch.valid)
    else $error("produced token not offered on the output");

  // Only the end token carries the final flag.
  a_final_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.final_item) |-> (out_ch.kind == K_END))
    else $error("final flag on a token other than end of input");

endmodule

// ===== hw/rtl/stu_lexer.sv =====
// Lexer state registers and the per-byte logic that yields up to three results.
module stu_lexer import stu_pkg::*; #(
  parameter int POS_BITS = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic                op,
  input  logic [7:0]          in_byte,
  output logic [NUM_W-1:0]    push_num,
  output res_fix_t            res_fix  [MAX_RES],
  output logic [POS_BITS-1:0] res_beg  [MAX_RES],
  output logic [POS_BITS-1:0] res_endp [MAX_RES]
);

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  mode_t               mode_r, mode_nxt;
  logic [POS_BITS-1:0] tok_start_r, tok_start_nxt;
  logic [POS_BITS-1:0] offset_r, offset_nxt;
  logic [VALUE_W-1:0]  acc_r, acc_nxt;
  logic [2:0]          kw_r, kw_nxt;

  logic [POS_BITS-1:0] pos, next_pos;
  logic                is_space, is_digit, is_alpha, is_cont, skip, restart;
  logic [VALUE_W-1:0]  acc_step;
  logic [2:0]          kw_step;
  punct_t              punct;
  logic [NUM_W-1:0]    n;
  logic                esc_bad;
  logic [7:0]          esc_val;

  assign pos      = offset_r;
  assign next_pos = (offset_r == POS_MAX) ? POS_MAX : offset_r + POS_BITS'(1);

  assign is_space = (in_byte == 8'h20) || (in_byte == CH_TAB) ||
                    ((in_byte >= CH_LF) && (in_byte <= CH_CR));
  assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
  assign is_alpha = ((in_byte >= 8'h61) && (in_byte <= 8'h7A)) ||
                    ((in_byte >= 8'h41) && (in_byte <= 8'h5A)) || (in_byte == 8'h5F);
  assign is_cont  = is_alpha || is_digit;
  assign skip     = is_space || (in_byte == CH_SLASH);
  assign punct    = punct_lookup(in_byte);

  // acc * 10 + digit as the sum of two shifted copies and the digit.
  assign acc_step = {acc_r[VALUE_W-4:0], 3'b000} + {acc_r[VALUE_W-2:0], 1'b0} +
                    {{(VALUE_W-4){1'b0}}, in_byte[3:0]};
  assign kw_step  = ((kw_r < KW_FULL) && (in_byte == kw_char(kw_r[1:0]))) ?
                    kw_r + 3'd1 : KW_NONE;

  always_comb begin
    esc_bad = 1'b0;
    unique case (in_byte)
      CH_N:    esc_val = CH_LF;
      CH_T:    esc_val = CH_TAB;
      CH_R:    esc_val = CH_CR;
      CH_ZERO: esc_val = CH_NUL;
      default: begin
        esc_val = CH_NUL;
        esc_bad = 1'b1;
      end
    endcase
  end

  // The byte starts fresh lexing when no token is pending or it ends an identifier or number.
  always_comb begin
    unique case (mode_r)
      MODE_IDENT:  restart = !is_cont;
      MODE_NUMBER: restart = !is_digit;
      MODE_STRING: restart = 1'b0;
      MODE_ESC:    restart = 1'b0;
      default:     restart = 1'b1;
    endcase
  end

  // Next-state logic.
  always_comb begin
    mode_nxt      = mode_r;
    tok_start_nxt = tok_start_r;
    offset_nxt    = offset_r;
    acc_nxt       = acc_r;
    kw_nxt        = kw_r;
    if (fire) begin
      if (op) begin
        mode_nxt      = MODE_IDLE;
        tok_start_nxt = '0;
        offset_nxt    = '0;
        acc_nxt       = '0;
        kw_nxt        = '0;
      end else begin
        offset_nxt = next_pos;
        unique case (mode_r)
          MODE_STRING: begin
            if (in_byte == CH_QUOTE) begin
              mode_nxt = MODE_IDLE;
            end else if (in_byte == CH_BSLASH) begin
              mode_nxt = MODE_ESC;
            end
          end
          MODE_ESC:    mode_nxt = MODE_STRING;
          MODE_IDENT:  if (is_cont) kw_nxt = kw_step;
          MODE_NUMBER: if (is_digit) acc_nxt = acc_step;
          default:     mode_nxt = mode_r;
        endcase
        if (restart) begin
          mode_nxt = MODE_IDLE;
          if (!skip && !punct.hit) begin
            if (in_byte == CH_QUOTE) begin
              mode_nxt      = MODE_STRING;
              tok_start_nxt = pos;
            end else if (is_alpha) begin
              mode_nxt      = MODE_IDENT;
              tok_start_nxt = pos;
              kw_nxt        = (in_byte == CH_F) ? KW_ONE : KW_NONE;
            end else if (is_digit) begin
              mode_nxt      = MODE_NUMBER;
              tok_start_nxt = pos;
              acc_nxt       = {{(VALUE_W-4){1'b0}}, in_byte[3:0]};
            end
          end
        end
      end
    end
  end

  // Result logic: fills the slots in emission order.
  always_comb begin
    n = '0;
    for (int i = 0; i < MAX_RES; i++) begin
      res_fix[i]  = '{kind: K_LPAREN, value: '0, final_item: 1'b0};
      res_beg[i]  = '0;
      res_endp[i] = '0;
    end
    if (op) begin
      if ((mode_r == MODE_STRING) || (mode_r == MODE_ESC)) begin
        res_fix[n]  = '{kind: K_UNFINISHED, value: '0, final_item: 1'b0};
        res_beg[n]  = tok_start_r;
        res_endp[n] = pos;
        n = n + 2'd1;
        res_fix[n]  = '{kind: K_STRING, value: '0, final_item: 1'b0};
        res_beg[n]  = tok_start_r;
        res_endp[n] = pos;
        n = n + 2'd1;
      end else if (mode_r == MODE_IDENT) begin
        res_fix[n]  = '{kind: (kw_r == KW_FULL) ? K_FUN : K_IDENT, value: '0,
                        final_item: 1'b0};
        res_beg[n]  = tok_start_r;
        res_endp[n] = pos;
        n = n + 2'd1;
      end else if (mode_r == MODE_NUMBER) begin
        res_fix[n]  = '{kind: K_INTEGER, value: acc_r, final_item: 1'b0};
        res_beg[n]  = tok_start_r;
        res_endp[n] = pos;
        n = n + 2'd1;
      end
      res_fix[n]  = '{kind: K_END, value: '0, final_item: 1'b1};
      res_beg[n]  = pos;
      res_endp[n] = pos;
      n = n + 2'd1;
    end else begin
      unique case (mode_r)
        MODE_STRING: begin
          if (in_byte == CH_QUOTE) begin
            res_fix[n]  = '{kind: K_STRING, value: '0, final_item: 1'b0};
            res_beg[n]  = tok_start_r;
            res_endp[n] = next_pos;
            n = n + 2'd1;
          end else if (in_byte != CH_BSLASH) begin
            res_fix[n]  = '{kind: K_STR_BYTE, value: {{(VALUE_W-8){1'b0}}, in_byte},
                            final_item: 1'b0};
            res_beg[n]  = pos;
            res_endp[n] = next_pos;
            n = n + 2'd1;
          end
        end
        MODE_ESC: begin
          if (esc_bad) begin
            res_fix[n]  = '{kind: K_BAD_ESC, value: '0, final_item: 1'b0};
            res_beg[n]  = pos;
            res_endp[n] = next_pos;
            n = n + 2'd1;
          end
          res_fix[n]  = '{kind: K_STR_BYTE, value: {{(VALUE_W-8){1'b0}}, esc_val},
                          final_item: 1'b0};
          res_beg[n]  = pos;
          res_endp[n] = next_pos;
          n = n + 2'd1;
        end
        MODE_IDENT: begin
          if (!is_cont) begin
            res_fix[n]  = '{kind: (kw_r == KW_FULL) ? K_FUN : K_IDENT, value: '0,
                            final_item: 1'b0};
            res_beg[n]  = tok_start_r;
            res_endp[n] = pos;
            n = n + 2'd1;
          end
        end
        MODE_NUMBER: begin
          if (!is_digit) begin
            res_fix[n]  = '{kind: K_INTEGER, value: acc_r, final_item: 1'b0};
            res_beg[n]  = tok_start_r;
            res_endp[n] = pos;
            n = n + 2'd1;
          end
        end
        default: n = n;
      endcase
      if (restart && !skip) begin
        if (punct.hit) begin
          res_fix[n]  = '{kind: punct.kind, value: '0, final_item: 1'b0};
          res_beg[n]  = pos;
          res_endp[n] = next_pos;
          n = n + 2'd1;
        end else if (!(in_byte == CH_QUOTE) && !is_alpha && !is_digit) begin
          res_fix[n]  = '{kind: K_UNEXPECTED, value: '0, final_item: 1'b0};
          res_beg[n]  = pos;
          res_endp[n] = next_pos;
          n = n + 2'd1;
        end
      end
    end
    push_num = fire ? n : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      tok_start_r <= '0;
      offset_r    <= '0;
      acc_r       <= '0;
      kw_r        <= '0;
    end else begin
      mode_r      <= mode_nxt;
      tok_start_r <= tok_start_nxt;
      offset_r    <= offset_nxt;
      acc_r       <= acc_nxt;
      kw_r        <= kw_nxt;
    end
  end

endmodule

// ===== hw/rtl/stu_result_fifo.sv =====
// Four-entry result queue that takes up to three results per cycle and gives one per beat.
module stu_result_fifo import stu_pkg::*; #(
  parameter int POS_BITS = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [NUM_W-1:0]    push_num,
  input  res_fix_t            push_fix  [MAX_RES],
  input  logic [POS_BITS-1:0] push_beg  [MAX_RES],
  input  logic [POS_BITS-1:0] push_endp [MAX_RES],
  input  logic                pop,
  output fifo_stat_t          stat,
  output res_fix_t            head_fix,
  output logic [POS_BITS-1:0] head_beg,
  output logic [POS_BITS-1:0] head_endp
);

  res_fix_t            fix_mem  [FIFO_DEPTH];
  logic [POS_BITS-1:0] beg_mem  [FIFO_DEPTH];
  logic [POS_BITS-1:0] endp_mem [FIFO_DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             pop_ok;

  assign pop_ok     = pop && (count_r != '0);
  assign wr_ptr_nxt = wr_ptr_r + PTR_W'(push_num);
  assign rd_ptr_nxt = rd_ptr_r + PTR_W'(pop_ok);
  assign count_nxt  = count_r + CNT_W'(push_num) - CNT_W'(pop_ok);

  assign stat.count     = count_r;
  assign stat.not_empty = (count_r != '0);
  assign stat.has_room  = (count_r <= CNT_W'(FIFO_DEPTH - MAX_RES));

  assign head_fix  = fix_mem[rd_ptr_r];
  assign head_beg  = beg_mem[rd_ptr_r];
  assign head_endp = endp_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (NUM_W'(i) < push_num) begin
        fix_mem[wr_ptr_r + PTR_W'(i)]  <= push_fix[i];
        beg_mem[wr_ptr_r + PTR_W'(i)]  <= push_beg[i];
        endp_mem[wr_ptr_r + PTR_W'(i)] <= push_endp[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
